// File: rtl/core/ptoh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptoh_pkg
// Shared types, codes and string tables for the text to html stream block.
// ----------------------------------------------------------------------------
package ptoh_pkg;

    localparam int MAX_SEGS = 5;
    localparam int MAX_SEG_LEN = 23;
    localparam int TEXT_W = 8 * MAX_SEG_LEN;
    localparam int LEN_W = 5;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // output segment kinds, in the order they may appear for one item
    typedef enum logic [3:0] {
        SEG_P_OPEN,
        SEG_TAG_PREFIX,
        SEG_BREAK,
        SEG_PARA,
        SEG_SPAN_CLOSE,
        SEG_GT,
        SEG_AMP,
        SEG_SPAN_OPEN,
        SEG_CHAR,
        SEG_P_CLOSE
    } seg_code_t;

    typedef struct packed {
        seg_code_t [MAX_SEGS-1:0] segs;
        logic [2:0]               count;
        logic [3:0]               prefix_len;
        logic [7:0]               ch;
    } plan_t;

    localparam logic [8*3-1:0]  S_P_OPEN     = "<p>";
    localparam logic [8*8-1:0]  S_TAG_PREFIX = "&lt;br /";
    localparam logic [8*5-1:0]  S_BREAK      = "<br/>";
    localparam logic [8*7-1:0]  S_PARA       = "</p><p>";
    localparam logic [8*7-1:0]  S_SPAN_CLOSE = "</span>";
    localparam logic [8*4-1:0]  S_GT         = "&gt;";
    localparam logic [8*5-1:0]  S_AMP        = "&amp;";
    localparam logic [8*23-1:0] S_SPAN_OPEN  = "<span class=\"footnote\">";
    localparam logic [8*4-1:0]  S_P_CLOSE    = "</p>";

    // segment text, first byte in the top byte
    function automatic logic [TEXT_W-1:0] seg_text(input seg_code_t code);
        logic [TEXT_W-1:0] t;
        t = '0;
        unique case (code)
            SEG_P_OPEN:     t = {S_P_OPEN, {20{8'h00}}};
            SEG_TAG_PREFIX: t = {S_TAG_PREFIX, {15{8'h00}}};
            SEG_BREAK:      t = {S_BREAK, {18{8'h00}}};
            SEG_PARA:       t = {S_PARA, {16{8'h00}}};
            SEG_SPAN_CLOSE: t = {S_SPAN_CLOSE, {16{8'h00}}};
            SEG_GT:         t = {S_GT, {19{8'h00}}};
            SEG_AMP:        t = {S_AMP, {18{8'h00}}};
            SEG_SPAN_OPEN:  t = S_SPAN_OPEN;
            SEG_P_CLOSE:    t = {S_P_CLOSE, {19{8'h00}}};
            default:        t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [LEN_W-1:0] seg_len(input seg_code_t code,
                                                 input logic [3:0] prefix_len);
        logic [LEN_W-1:0] n;
        n = 5'd1;
        unique case (code)
            SEG_P_OPEN:     n = 5'd3;
            SEG_TAG_PREFIX: n = {1'b0, prefix_len};
            SEG_BREAK:      n = 5'd5;
            SEG_PARA:       n = 5'd7;
            SEG_SPAN_CLOSE: n = 5'd7;
            SEG_GT:         n = 5'd4;
            SEG_AMP:        n = 5'd5;
            SEG_SPAN_OPEN:  n = 5'd23;
            SEG_CHAR:       n = 5'd1;
            SEG_P_CLOSE:    n = 5'd4;
            default:        n = 5'd1;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/ptoh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptoh_front
// Accepts input items, tracks paragraph, newline, footnote and break tag
// state, and turns each item into a list of output segments.
// ----------------------------------------------------------------------------
module ptoh_front
    import ptoh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_char_in,
    output logic       plan_valid,
    input  logic       plan_ready,
    output plan_t      plan
);

    localparam logic [2:0] TAG_LAST = 3'd5;

    logic       opened_reg, opened_next;
    logic       emitted_reg, emitted_next;
    logic       in_fn_reg, in_fn_next;
    logic [1:0] nl_reg, nl_next;
    logic [2:0] prog_reg, prog_next;
    logic       accept;

    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (pos)
            3'd1:    c = 8'h62;
            3'd2:    c = 8'h72;
            3'd3:    c = 8'h20;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h3E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign s_ready = plan_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [2:0] n;
        logic       take;
        n            = 3'd0;
        take         = 1'b0;
        plan         = '0;
        plan.ch      = s_char_in;
        opened_next  = 1'b1;
        emitted_next = emitted_reg;
        in_fn_next   = in_fn_reg;
        nl_next      = nl_reg;
        prog_next    = prog_reg;

        if (!opened_reg) begin
            plan.segs[n] = SEG_P_OPEN;
            n = n + 3'd1;
        end

        if (s_opcode == OP_TEXT) begin
            if (prog_reg != 3'd0) begin
                if (s_char_in == tag_char(prog_reg)) begin
                    if (prog_reg == TAG_LAST) begin
                        plan.segs[n] = SEG_BREAK;
                        n = n + 3'd1;
                        emitted_next = 1'b1;
                        prog_next = 3'd0;
                    end else begin
                        prog_next = prog_reg + 3'd1;
                    end
                end else begin
                    plan.segs[n] = SEG_TAG_PREFIX;
                    n = n + 3'd1;
                    plan.prefix_len = {1'b0, prog_reg} + 4'd3;
                    emitted_next = 1'b1;
                    prog_next = 3'd0;
                    take = 1'b1;
                end
            end else begin
                take = 1'b1;
            end

            if (take) begin
                if (s_char_in == CH_NL) begin
                    if (emitted_next && nl_reg != 2'd2) begin
                        nl_next = nl_reg + 2'd1;
                    end
                end else begin
                    if (nl_reg == 2'd1) begin
                        plan.segs[n] = SEG_BREAK;
                        n = n + 3'd1;
                        emitted_next = 1'b1;
                    end else if (nl_reg == 2'd2) begin
                        plan.segs[n] = SEG_PARA;
                        n = n + 3'd1;
                        emitted_next = 1'b1;
                    end
                    nl_next = 2'd0;
                    unique case (s_char_in)
                        CH_LT: begin
                            prog_next = 3'd1;
                        end
                        CH_GT: begin
                            plan.segs[n] = SEG_GT;
                            n = n + 3'd1;
                            emitted_next = 1'b1;
                        end
                        CH_AMP: begin
                            plan.segs[n] = SEG_AMP;
                            n = n + 3'd1;
                            emitted_next = 1'b1;
                        end
                        CH_LBRACE: begin
                            plan.segs[n] = in_fn_reg ? SEG_CHAR : SEG_SPAN_OPEN;
                            n = n + 3'd1;
                            in_fn_next = 1'b1;
                            emitted_next = 1'b1;
                        end
                        CH_RBRACE: begin
                            if (in_fn_reg) begin
                                plan.segs[n] = SEG_SPAN_CLOSE;
                                n = n + 3'd1;
                                in_fn_next = 1'b0;
                            end
                            plan.segs[n] = SEG_CHAR;
                            n = n + 3'd1;
                            emitted_next = 1'b1;
                        end
                        default: begin
                            plan.segs[n] = SEG_CHAR;
                            n = n + 3'd1;
                            emitted_next = 1'b1;
                        end
                    endcase
                end
            end
        end else begin
            if (prog_reg != 3'd0) begin
                plan.segs[n] = SEG_TAG_PREFIX;
                n = n + 3'd1;
                plan.prefix_len = {1'b0, prog_reg} + 4'd3;
            end
            if (nl_reg == 2'd1) begin
                plan.segs[n] = SEG_BREAK;
                n = n + 3'd1;
            end else if (nl_reg == 2'd2) begin
                plan.segs[n] = SEG_PARA;
                n = n + 3'd1;
            end
            if (in_fn_reg) begin
                plan.segs[n] = SEG_SPAN_CLOSE;
                n = n + 3'd1;
            end
            plan.segs[n] = SEG_P_CLOSE;
            n = n + 3'd1;
            opened_next  = 1'b0;
            emitted_next = 1'b0;
            in_fn_next   = 1'b0;
            nl_next      = 2'd0;
            prog_next    = 3'd0;
        end

        plan.count = n;
    end

    assign plan_valid = accept && (plan.count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opened_reg  <= 1'b0;
            emitted_reg <= 1'b0;
            in_fn_reg   <= 1'b0;
            nl_reg      <= 2'd0;
            prog_reg    <= 3'd0;
        end else if (accept) begin
            opened_reg  <= opened_next;
            emitted_reg <= emitted_next;
            in_fn_reg   <= in_fn_next;
            nl_reg      <= nl_next;
            prog_reg    <= prog_next;
        end
    end

endmodule

// File: rtl/core/ptoh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptoh_queue
// Short register queue of segment lists between the front and back parts.
// ----------------------------------------------------------------------------
module ptoh_queue
    import ptoh_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  plan_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output plan_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    plan_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_data  = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/core/ptoh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptoh_back
// Walks the segment list at the queue head and sends one html byte per
// cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module ptoh_back
    import ptoh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  plan_t      head_data,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       m_end_of_document
);

    logic [2:0]        slot_reg, slot_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              eod_reg;

    seg_code_t         code;
    logic [LEN_W-1:0]  len;
    logic [TEXT_W-1:0] text_shifted;
    logic [7:0]        cur_byte;
    logic              last_byte, last_seg, advance;

    assign code         = head_data.segs[slot_reg];
    assign len          = seg_len(code, head_data.prefix_len);
    assign text_shifted = seg_text(code) << {idx_reg, 3'b000};
    assign cur_byte     = (code == SEG_CHAR) ? head_data.ch
                                             : text_shifted[TEXT_W-1 -: 8];
    assign last_byte    = (idx_reg == len - 5'd1);
    assign last_seg     = (slot_reg == head_data.count - 3'd1);
    assign advance      = head_valid && (!m_valid_reg || m_ready);
    assign pop          = advance && last_byte && last_seg;

    always_comb begin
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            if (last_byte) begin
                idx_next  = '0;
                slot_next = last_seg ? 3'd0 : slot_reg + 3'd1;
            end else begin
                idx_next = idx_reg + 5'd1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= 3'd0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            slot_reg    <= slot_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg <= cur_byte;
            last_reg <= last_byte && last_seg;
            eod_reg  <= last_byte && last_seg && (code == SEG_P_CLOSE);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = byte_reg;
    assign m_last_of_run     = last_reg;
    assign m_end_of_document = eod_reg;

endmodule

// File: rtl/core/plain_text_to_html_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plain_text_to_html_stream
// Plain text byte stream to html byte stream with entity escaping,
// paragraph and line break handling and footnote spans.
//
//   channel   ports                                       direction
//   input     s_valid s_ready s_opcode s_char_in          in
//   result    m_valid m_ready m_out_byte m_last_of_run    out
//             m_end_of_document
//
// the front part takes one item per cycle while the segment queue has room
// the back part sends one html byte per cycle while the receiver is ready; an
// item expands to between 1 and 31 bytes; items with no output (held newlines,
// partial break tag) never reach the queue
// aresetn clears all state; both sides stall independently through the queue
// ----------------------------------------------------------------------------
module plain_text_to_html_stream
    import ptoh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       m_end_of_document
);

    plan_t plan;
    plan_t head_data;
    logic  plan_valid;
    logic  queue_full;
    logic  head_valid;
    logic  pop;

    ptoh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_char_in  (s_char_in),
        .plan_valid (plan_valid),
        .plan_ready (!queue_full),
        .plan       (plan)
    );

    ptoh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (plan_valid),
        .push_data  (plan),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ptoh_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head_data         (head_data),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_last_of_run     (m_last_of_run),
        .m_end_of_document (m_end_of_document)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text to html stream block. Directed items cover
// the opening paragraph, entity escapes, newline folding, the break tag with
// its broken forms and footnote spans; random documents with random idling on
// both sides follow, plus one long receiver hold-off that backs up the input.
// Every accepted item is run through an in-bench predictor and each html byte
// is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb;
    import ptoh_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int GAP_MAX        = 17;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 440;
    localparam int SHOWN_ERRORS   = 10;
    localparam string BREAK_TAG   = "<br />";
    localparam string SPAN_OPEN   = "<span class=\"footnote\">";

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       doc_end;
    } html_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_opcode = OP_TEXT;
    logic [7:0] s_char_in = 8'h20;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;
    logic       m_end_of_document;

    // predictor state
    logic       para_open = 1'b0;
    logic       content_seen = 1'b0;
    logic       note_open = 1'b0;
    logic [1:0] nl_held = 2'd0;
    logic [2:0] tag_len = 3'd0;
    logic [7:0] run_bytes[$];
    html_byte_t html_expected[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  s_gap_max = GAP_MAX;
    int  m_gap_max = GAP_MAX;
    bit  hold_request = 1'b0;
    int  stall_cycles = 0;

    plain_text_to_html_stream i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_char_in         (s_char_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_last_of_run     (m_last_of_run),
        .m_end_of_document (m_end_of_document)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic void put_str(string s, bit content);
        int i;
        for (i = 0; i < s.len(); i++) begin
            run_bytes.push_back(s[i]);
        end
        if (content) begin
            content_seen = 1'b1;
        end
    endfunction

    function automatic void put_char(logic [7:0] c);
        run_bytes.push_back(c);
        content_seen = 1'b1;
    endfunction

    function automatic void flush_newlines();
        if (nl_held == 2'd1) begin
            put_str("<br/>", 1'b1);
        end else if (nl_held >= 2'd2) begin
            put_str("</p><p>", 1'b1);
        end
        nl_held = 2'd0;
    endfunction

    // held bytes of a partial break tag go out with the bracket escaped
    function automatic void flush_tag();
        int i;
        if (tag_len != 3'd0) begin
            put_str("&lt;", 1'b1);
            for (i = 1; i < int'(tag_len); i++) begin
                put_char(BREAK_TAG[i]);
            end
            tag_len = 3'd0;
        end
    endfunction

    function automatic void take_char(logic [7:0] c);
        if (c == CH_NL) begin
            if (content_seen && nl_held < 2'd2) begin
                nl_held = nl_held + 2'd1;
            end
        end else begin
            flush_newlines();
            case (c)
                CH_LT: tag_len = 3'd1;
                CH_GT: put_str("&gt;", 1'b1);
                CH_AMP: put_str("&amp;", 1'b1);
                CH_LBRACE: begin
                    if (note_open) begin
                        put_char(c);
                    end else begin
                        put_str(SPAN_OPEN, 1'b1);
                        note_open = 1'b1;
                    end
                end
                CH_RBRACE: begin
                    if (note_open) begin
                        put_str("</span>", 1'b1);
                        note_open = 1'b0;
                    end
                    put_char(c);
                end
                default: put_char(c);
            endcase
        end
    endfunction

    function automatic void predict_html(logic op, logic [7:0] c);
        int doc_end_at;
        int i;
        html_byte_t hb;
        run_bytes.delete();
        doc_end_at = -1;
        if (!para_open) begin
            put_str("<p>", 1'b0);
            para_open = 1'b1;
        end
        if (op == OP_TEXT) begin
            if (tag_len != 3'd0) begin
                if (c == BREAK_TAG[int'(tag_len)]) begin
                    tag_len = tag_len + 3'd1;
                    if (tag_len == 3'd6) begin
                        put_str("<br/>", 1'b1);
                        tag_len = 3'd0;
                    end
                end else begin
                    flush_tag();
                    take_char(c);
                end
            end else begin
                take_char(c);
            end
        end else begin
            flush_tag();
            flush_newlines();
            if (note_open) begin
                put_str("</span>", 1'b0);
            end
            put_str("</p>", 1'b0);
            doc_end_at = run_bytes.size() - 1;
            para_open = 1'b0;
            content_seen = 1'b0;
            note_open = 1'b0;
            nl_held = 2'd0;
            tag_len = 3'd0;
        end
        for (i = 0; i < run_bytes.size(); i++) begin
            hb.data = run_bytes[i];
            hb.run_end = (i == run_bytes.size() - 1);
            hb.doc_end = (i == doc_end_at);
            html_expected.push_back(hb);
        end
    endfunction

    // prediction and checking, both on sampled handshakes
    always @(posedge aclk) begin
        html_byte_t exp_hb;
        html_byte_t got_hb;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_html(s_opcode, s_char_in);
            end
            if (m_valid && m_ready) begin
                got_hb = '{m_out_byte, m_last_of_run, m_end_of_document};
                if (html_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("%0t: unexpected html byte %h last %b end %b", $realtime,
                                 got_hb.data, got_hb.run_end, got_hb.doc_end);
                    end
                end else begin
                    exp_hb = html_expected.pop_front();
                    if (got_hb !== exp_hb) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS) begin
                            $display("%0t: html byte exp %h/%b/%b got %h/%b/%b", $realtime,
                                     exp_hb.data, exp_hb.run_end, exp_hb.doc_end,
                                     got_hb.data, got_hb.run_end, got_hb.doc_end);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random wait per item, one long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = (m_gap_max == 0) ? 0 : $urandom_range(0, m_gap_max);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_item(logic op, logic [7:0] c);
        int gap;
        gap = (s_gap_max == 0) ? 0 : $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_char_in <= c;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_item(OP_TEXT, s[i]);
        end
    endtask

    task automatic test_opening_and_escapes();
        send_item(OP_END, 8'hFF);
        send_item(OP_TEXT, 8'h01);
        send_item(OP_TEXT, CH_AMP);
        send_item(OP_TEXT, CH_GT);
        send_item(OP_TEXT, 8'hFF);
    endtask

    task automatic test_newlines();
        send_item(OP_END, 8'h80);
        send_text("\n\na\nb\n\n\n");
    endtask

    task automatic test_break_tag();
        send_text("<br /><<x<br");
        send_item(OP_END, 8'h7F);
    endtask

    task automatic test_footnotes();
        send_text("{{}}{\n");
        send_item(OP_END, 8'h01);
    endtask

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 15))
            0, 1: return CH_NL;
            2: return CH_LT;
            3: return CH_GT;
            4: return CH_AMP;
            5: return CH_LBRACE;
            6: return CH_RBRACE;
            7, 8, 9, 10, 11: return 8'($urandom_range(8'h20, 8'h7E));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic test_random_documents();
        int doc_items;
        int i;
        int k;
        while (items_sent < RANDOM_ITEMS) begin
            s_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            m_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            doc_items = $urandom_range(0, 40);
            i = 0;
            while (i < doc_items) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_text(BREAK_TAG);
                        i += 6;
                    end
                    1: begin
                        for (k = 0; k < $urandom_range(1, 5); k++) begin
                            send_item(OP_TEXT, BREAK_TAG[k]);
                            i++;
                        end
                    end
                    default: begin
                        send_item(OP_TEXT, pick_text_char());
                        i++;
                    end
                endcase
            end
            send_item(OP_END, 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic test_input_backpressure();
        int i;
        s_gap_max = 0;
        m_gap_max = GAP_MAX;
        hold_request = 1'b1;
        send_item(OP_TEXT, CH_LBRACE);
        for (i = 0; i < 30; i++) begin
            send_item(OP_TEXT, CH_AMP);
        end
        send_item(OP_END, 8'h55);
        s_gap_max = GAP_MAX;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_opening_and_escapes();
        test_newlines();
        test_break_tag();
        test_footnotes();
        test_random_documents();
        test_input_backpressure();
        s_valid <= 1'b0;
        while (html_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && html_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: plain_text_to_html_stream.f
rtl/core/ptoh_pkg.sv
rtl/core/ptoh_front.sv
rtl/core/ptoh_queue.sv
rtl/core/ptoh_back.sv
rtl/core/plain_text_to_html_stream.sv
test/tb.sv
